/* sv/spt_pkg.sv */
package spt_pkg;
   localparam int COORD_FRAC_BITS = 4;
   localparam int COORD_INT_BITS = 11;
   localparam int COORD_W = COORD_INT_BITS + COORD_FRAC_BITS;
   localparam int OUT_WIDTH = 32;
   localparam int CSR_W = 16;
   localparam int IDX_W = 2;
   // Numerators reach about 2^(16+16+8) plus sign; 48 bits of magnitude is ample.
   localparam int NUM_W = 48;
   localparam int DEN_W = COORD_W + 9;
   localparam int CNT_W = 6;

   localparam logic [IDX_W-1:0] CSR_FOCAL = 2'd0;
   localparam logic [IDX_W-1:0] CSR_BASE = 2'd1;
   localparam logic [IDX_W-1:0] CSR_WIDTH = 2'd2;
   localparam logic [IDX_W-1:0] CSR_HEIGHT = 2'd3;

   localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_DIV, ST_STORE, ST_BOX, ST_OUT
   } state_type;

   typedef enum logic [1:0] { AX_Z, AX_X, AX_Y } axis_type;

   typedef struct packed {
      logic     load;     // latch inputs, multiply focal*baseline
      logic     start;    // start division of selected axis
      logic     step;     // one divider iteration
      logic     store;    // store quotient of selected axis
      axis_type axis;
      logic     box;      // update box and build result
      logic     clear;    // clear box after a last_pair result is taken
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last;
   } sts_type;
endpackage

/* sv/spt_if.sv */
interface spt_req_if;
   import spt_pkg::*;
   logic valid;
   logic ready;
   logic [COORD_W-1:0] left_x;
   logic [COORD_W-1:0] left_y;
   logic [COORD_W-1:0] right_x;
   logic [COORD_W-1:0] right_y;
   logic last_pair;
   modport source (output valid, left_x, left_y, right_x, right_y, last_pair, input ready);
   modport sink (input valid, left_x, left_y, right_x, right_y, last_pair, output ready);
endinterface

interface spt_rsp_if;
   import spt_pkg::*;
   logic valid;
   logic ready;
   logic signed [OUT_WIDTH-1:0] point_x;
   logic signed [OUT_WIDTH-1:0] point_y;
   logic signed [OUT_WIDTH-1:0] point_z;
   logic bad_disparity;
   logic signed [OUT_WIDTH-1:0] center_x;
   logic signed [OUT_WIDTH-1:0] center_y;
   logic signed [OUT_WIDTH-1:0] center_z;
   logic [OUT_WIDTH-1:0] extent_x;
   logic [OUT_WIDTH-1:0] extent_y;
   logic [OUT_WIDTH-1:0] extent_z;
   logic summary_valid;
   modport source (output valid, point_x, point_y, point_z, bad_disparity, center_x,
      center_y, center_z, extent_x, extent_y, extent_z, summary_valid, input ready);
   modport sink (input valid, point_x, point_y, point_z, bad_disparity, center_x,
      center_y, center_z, extent_x, extent_y, extent_z, summary_valid, output ready);
endinterface

/* sv/stereo_point_triangulator.sv */
// Rectified stereo triangulation. Each transaction on req carries a matched
// left/right pixel pair in unsigned Q11.4; the rsp transaction returns the
// 3D point in signed Q27.4 (z negative in front of the rig), saturated, plus
// the running bounding box center and size. A zero disparity sets
// bad_disparity, saturates the point by the sign of each numerator and keeps
// it out of the box. The box is cleared once the result of a pair marked
// last_pair has been taken. One transaction is processed at a time; each
// goes from acceptance to rsp_valid through one setup step, then three
// divisions, each producing a 49-bit quotient bit by bit and followed by a
// finishing step and a store step, on one shared radix-2 restoring
// divider, then a box update. The next req transaction can be accepted in
// the cycle after the rsp transaction is taken. The csr port may be written
// only while idle.
module stereo_point_triangulator
   import spt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   spt_req_if.sink           req,
   spt_rsp_if.source         rsp,
   input  logic              csr_write,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_data
);
   logic [CSR_W-1:0] focal_ff, base_ff;
   logic [11:0]      width_ff, height_ff;
   cmd_type cmd;
   sts_type sts;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= 16'd11968;
         base_ff <= 16'd2560;
         width_ff <= 12'd600;
         height_ff <= 12'd450;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FOCAL: focal_ff <= csr_data;
            CSR_BASE: base_ff <= csr_data;
            CSR_WIDTH: width_ff <= csr_data[11:0];
            default: height_ff <= csr_data[11:0];
         endcase
      end
   end

   spt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts(sts), .cmd(cmd)
   );

   spt_dp u_dp (
      .clock(clock), .cmd(cmd), .sts(sts), .reset(reset),
      .focal(focal_ff), .base(base_ff), .img_w(width_ff), .img_h(height_ff),
      .left_x(req.left_x), .left_y(req.left_y), .right_x(req.right_x),
      .right_y(req.right_y), .last_pair(req.last_pair),
      .point_x(rsp.point_x), .point_y(rsp.point_y), .point_z(rsp.point_z),
      .bad_disparity(rsp.bad_disparity),
      .center_x(rsp.center_x), .center_y(rsp.center_y), .center_z(rsp.center_z),
      .extent_x(rsp.extent_x), .extent_y(rsp.extent_y), .extent_z(rsp.extent_z),
      .summary_valid(rsp.summary_valid)
   );
endmodule

/* sv/spt_ctrl.sv */
module spt_ctrl
   import spt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;
   axis_type  axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff <= AX_Z;
      end else begin
         state_ff <= state_in;
         axis_ff <= axis_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_PREP;
         ST_PREP: begin
            state_in = ST_DIV;
            axis_in = AX_Z;
         end
         ST_DIV: if (sts.div_done) state_in = ST_STORE;
         ST_STORE: begin
            unique case (axis_ff)
               AX_Z: begin axis_in = AX_X; state_in = ST_DIV; end
               AX_X: begin axis_in = AX_Y; state_in = ST_DIV; end
               default: state_in = ST_BOX;
            endcase
         end
         ST_BOX: state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.axis = axis_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_PREP: begin
            cmd.start = 1'b1;
            cmd.axis = AX_Z;
         end
         ST_DIV: cmd.step = 1'b1;
         ST_STORE: begin
            cmd.store = 1'b1;
            cmd.start = (axis_ff != AX_Y);
            cmd.axis = axis_ff;
         end
         ST_BOX: cmd.box = 1'b1;
         ST_OUT: begin
            rsp_valid = 1'b1;
            cmd.clear = rsp_ready && sts.last;
         end
         default: ;
      endcase
   end
endmodule

/* sv/spt_dp.sv */
module spt_dp
   import spt_pkg::*;
(
   input  logic                 clock,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic                 reset,
   input  logic [CSR_W-1:0]     focal,
   input  logic [CSR_W-1:0]     base,
   input  logic [11:0]          img_w,
   input  logic [11:0]          img_h,
   input  logic [COORD_W-1:0]   left_x,
   input  logic [COORD_W-1:0]   left_y,
   input  logic [COORD_W-1:0]   right_x,
   input  logic [COORD_W-1:0]   right_y,
   input  logic                 last_pair,
   output logic signed [OUT_WIDTH-1:0] point_x,
   output logic signed [OUT_WIDTH-1:0] point_y,
   output logic signed [OUT_WIDTH-1:0] point_z,
   output logic                 bad_disparity,
   output logic signed [OUT_WIDTH-1:0] center_x,
   output logic signed [OUT_WIDTH-1:0] center_y,
   output logic signed [OUT_WIDTH-1:0] center_z,
   output logic [OUT_WIDTH-1:0] extent_x,
   output logic [OUT_WIDTH-1:0] extent_y,
   output logic [OUT_WIDTH-1:0] extent_z,
   output logic                 summary_valid
);
   localparam int QW = NUM_W + 1;
   localparam int RW = DEN_W + 2;

   logic [NUM_W-1:0] mx_ff, my_ff, mx_in, my_in;
   logic             sx_ff, sy_ff, sx_in, sy_in;
   logic [COORD_W-1:0] ad_ff;
   logic             dneg_ff, last_ff, bad_ff;
   logic [CSR_W-1:0] base_ff;
   logic [2*CSR_W-1:0] fb_ff;
   logic signed [COORD_W+1:0] tx_ff, ty_ff;

   // divider: (2n + D) / (2D), restoring, one quotient bit per cycle
   logic [QW-1:0]   dq_ff;
   logic [RW-1:0]   dr_ff;
   logic [DEN_W:0]  dd_ff;
   logic [CNT_W-1:0] dc_ff;
   logic            dsg_ff;
   logic [RW-1:0]   dr_sh, dr_sub;

   logic signed [OUT_WIDTH-1:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [OUT_WIDTH-1:0] bminx_ff, bmaxx_ff, bminy_ff, bmaxy_ff, bminz_ff, bmaxz_ff;
   logic signed [OUT_WIDTH-1:0] cx_ff, cy_ff, cz_ff;
   logic [OUT_WIDTH-1:0] ex_ff, ey_ff, ez_ff;

   logic signed [COORD_W:0] d_full;
   logic signed [COORD_W+1:0] tx_c, ty_c;
   logic [NUM_W-1:0] sel_m;
   logic sel_s;
   logic [DEN_W:0] sel_d2;
   logic [QW-1:0] qsat;
   logic signed [OUT_WIDTH-1:0] qres;

   always_comb begin
      d_full = $signed({1'b0, left_x}) - $signed({1'b0, right_x});
      tx_c = $signed({1'b0, left_x, 1'b0}) - $signed({1'b0, img_w, {COORD_FRAC_BITS{1'b0}}});
      ty_c = $signed({1'b0, img_h, {COORD_FRAC_BITS{1'b0}}})
           - $signed({2'b0, left_y} + {2'b0, right_y});
   end

   // load stage: latch terms, multiply focal*baseline
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ad_ff <= d_full[COORD_W] ? COORD_W'(-d_full) : d_full[COORD_W-1:0];
         dneg_ff <= d_full[COORD_W];
         bad_ff <= (d_full == '0);
         last_ff <= last_pair;
         base_ff <= base;
         fb_ff <= focal * base;
         tx_ff <= tx_c;
         ty_ff <= ty_c;
      end
   end

   // numerator magnitudes/signs, formed on start of the z division
   logic [COORD_W+1:0] atx, aty;
   logic [COORD_W+CSR_W+1:0] prod_x, prod_y;
   always_comb begin
      atx = tx_ff[COORD_W+1] ? (COORD_W+2)'(-tx_ff) : tx_ff;
      aty = ty_ff[COORD_W+1] ? (COORD_W+2)'(-ty_ff) : ty_ff;
      prod_x = atx * base_ff;
      prod_y = aty * base_ff;
      mx_in = mx_ff; my_in = my_ff;
      sx_in = sx_ff; sy_in = sy_ff;
      if (cmd.start && cmd.axis == AX_Z && !cmd.store) begin
         mx_in = NUM_W'({prod_x, 4'b0});
         sx_in = tx_ff[COORD_W+1];
         my_in = NUM_W'({prod_y, 4'b0});
         sy_in = ty_ff[COORD_W+1];
      end
   end
   always_ff @(posedge clock) begin
      mx_ff <= mx_in; my_ff <= my_in;
      sx_ff <= sx_in; sy_ff <= sy_in;
   end

   axis_type next_axis;
   always_comb begin
      next_axis = cmd.axis;
      if (cmd.store) begin
         unique case (cmd.axis)
            AX_Z: next_axis = AX_X;
            default: next_axis = AX_Y;
         endcase
      end
      unique case (next_axis)
         AX_Z: begin sel_m = NUM_W'({fb_ff, 8'b0}); sel_s = (fb_ff != '0); end
         AX_X: begin sel_m = mx_ff; sel_s = sx_ff; end
         default: begin sel_m = my_ff; sel_s = sy_ff; end
      endcase
      if (next_axis == AX_Z) sel_d2 = (DEN_W+1)'({ad_ff, 9'b0});
      else sel_d2 = (DEN_W+1)'({ad_ff, 6'b0});
      dr_sh = {dr_ff[RW-2:0], dq_ff[QW-1]};
      dr_sub = dr_sh - RW'(dd_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff <= '0;
      end else if (cmd.start) begin
         // numerator 2n + D (D = den), divisor 2D
         dq_ff <= QW'({sel_m, 1'b0}) + QW'(sel_d2 >> 1);
         dr_ff <= '0;
         dd_ff <= sel_d2;
         dsg_ff <= sel_s ^ dneg_ff;
         dc_ff <= CNT_W'(QW);
      end else if (cmd.step && dc_ff != '0) begin
         if (!dr_sub[RW-1]) begin
            dr_ff <= dr_sub;
            dq_ff <= {dq_ff[QW-2:0], 1'b1};
         end else begin
            dr_ff <= dr_sh;
            dq_ff <= {dq_ff[QW-2:0], 1'b0};
         end
         dc_ff <= dc_ff - 1'b1;
      end
   end
   assign sts.div_done = cmd.step && (dc_ff == '0);
   assign sts.last = last_ff;

   always_comb begin
      qsat = (dq_ff > QW'(OUT_MAX)) ? QW'(OUT_MAX) + QW'(dsg_ff) : dq_ff;
      qres = dsg_ff ? OUT_WIDTH'(-qsat) : OUT_WIDTH'(qsat);
   end

   function automatic logic signed [OUT_WIDTH-1:0] sgn_sat(input logic nz, input logic s);
      if (!nz) return '0;
      return s ? OUT_MIN : OUT_MAX;
   endfunction

   always_comb begin
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      if (cmd.store) begin
         unique case (cmd.axis)
            AX_Z: pz_in = bad_ff ? sgn_sat(fb_ff != '0, 1'b1) : qres;
            AX_X: px_in = bad_ff ? sgn_sat(mx_ff != '0, sx_ff) : qres;
            default: py_in = bad_ff ? sgn_sat(my_ff != '0, sy_ff) : qres;
         endcase
      end
   end
   always_ff @(posedge clock) begin
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
   end

   logic signed [OUT_WIDTH-1:0] nminx, nmaxx, nminy, nmaxy, nminz, nmaxz;
   always_comb begin
      nminx = bminx_ff; nmaxx = bmaxx_ff; nminy = bminy_ff;
      nmaxy = bmaxy_ff; nminz = bminz_ff; nmaxz = bmaxz_ff;
      if (!bad_ff) begin
         if (px_ff < nminx) nminx = px_ff;
         if (px_ff > nmaxx) nmaxx = px_ff;
         if (py_ff < nminy) nminy = py_ff;
         if (py_ff > nmaxy) nmaxy = py_ff;
         if (pz_ff < nminz) nminz = pz_ff;
         if (pz_ff > nmaxz) nmaxz = pz_ff;
      end
   end

   function automatic logic signed [OUT_WIDTH-1:0] ctr(input logic signed [OUT_WIDTH-1:0] lo,
                                                       input logic signed [OUT_WIDTH-1:0] hi);
      logic signed [OUT_WIDTH:0] s;
      s = '0;
      if (lo > hi) return '0;
      s = (OUT_WIDTH+1)'(lo) + (OUT_WIDTH+1)'(hi);
      return s[OUT_WIDTH:1];
   endfunction
   function automatic logic [OUT_WIDTH-1:0] ext(input logic signed [OUT_WIDTH-1:0] lo,
                                               input logic signed [OUT_WIDTH-1:0] hi);
      if (lo > hi) return '0;
      return OUT_WIDTH'(hi - lo);
   endfunction

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         bminx_ff <= OUT_MAX; bmaxx_ff <= OUT_MIN;
         bminy_ff <= OUT_MAX; bmaxy_ff <= OUT_MIN;
         bminz_ff <= OUT_MAX; bmaxz_ff <= OUT_MIN;
      end else if (cmd.box) begin
         bminx_ff <= nminx; bmaxx_ff <= nmaxx;
         bminy_ff <= nminy; bmaxy_ff <= nmaxy;
         bminz_ff <= nminz; bmaxz_ff <= nmaxz;
      end
      if (cmd.box) begin
         cx_ff <= ctr(nminx, nmaxx); ex_ff <= ext(nminx, nmaxx);
         cy_ff <= ctr(nminy, nmaxy); ey_ff <= ext(nminy, nmaxy);
         cz_ff <= ctr(nminz, nmaxz); ez_ff <= ext(nminz, nmaxz);
      end
   end

   assign point_x = px_ff;
   assign point_y = py_ff;
   assign point_z = pz_ff;
   assign bad_disparity = bad_ff;
   assign center_x = cx_ff;
   assign center_y = cy_ff;
   assign center_z = cz_ff;
   assign extent_x = ex_ff;
   assign extent_y = ey_ff;
   assign extent_z = ez_ff;
   assign summary_valid = last_ff;
endmodule

/* sv/spt_checker.sv */
module spt_checker
   import spt_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic bad_disparity,
   input logic [OUT_WIDTH-1:0] extent_x
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while result pending");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
   a_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready) else $error("not idle after result");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(bad_disparity) && $stable(extent_x)))
      else $error("result changed while waiting");
endmodule

bind stereo_point_triangulator spt_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .bad_disparity(rsp.bad_disparity), .extent_x(rsp.extent_x)
);

/* dv/stereo_point_triangulator_tb.sv */
`timescale 1ns / 1ps

module stereo_point_triangulator_tb;
   import spt_pkg::*;

   // The checker compares each field of every response against the oldest prediction.
   // The watchdog gives up after this many cycles in which neither channel moves.
   // The longest correct gap is one long response stall plus one computation.
   localparam int STALL_LIMIT = 12000;
   localparam int HOLD_CYCLES = 3000;
   localparam int DRAIN_CYCLES = 200;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   typedef struct {
      logic [COORD_W-1:0] left_x;
      logic [COORD_W-1:0] left_y;
      logic [COORD_W-1:0] right_x;
      logic [COORD_W-1:0] right_y;
      logic               last_pair;
   } pixel_pair_type;

   typedef struct {
      logic [OUT_WIDTH-1:0] point_x;
      logic [OUT_WIDTH-1:0] point_y;
      logic [OUT_WIDTH-1:0] point_z;
      logic                 bad_disparity;
      logic [OUT_WIDTH-1:0] center_x;
      logic [OUT_WIDTH-1:0] center_y;
      logic [OUT_WIDTH-1:0] center_z;
      logic [OUT_WIDTH-1:0] extent_x;
      logic [OUT_WIDTH-1:0] extent_y;
      logic [OUT_WIDTH-1:0] extent_z;
      logic                 summary_valid;
   } scene_point_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_data;

   spt_req_if req_if ();
   spt_rsp_if rsp_if ();

   stereo_point_triangulator dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow copy of the registers and of the running bounding box.
   logic [15:0] focal_q;
   logic [15:0] base_q;
   logic [11:0] width_px;
   logic [11:0] height_px;
   longint box_lo_x, box_hi_x, box_lo_y, box_hi_y, box_lo_z, box_hi_z;

   scene_point_type expected_points[$];
   int mismatches = 0;

   // Idle rates in percent, and the request for one long response hold-off.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_mode = 1'b0;
   int hold_count = 0;

   function automatic void clear_box();
      box_lo_x = SAT_HI; box_hi_x = SAT_LO;
      box_lo_y = SAT_HI; box_hi_y = SAT_LO;
      box_lo_z = SAT_HI; box_hi_z = SAT_LO;
   endfunction

   function automatic longint clamp_out(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   function automatic longint sign_limit(longint n);
      if (n > 0) return SAT_HI;
      if (n < 0) return SAT_LO;
      return 0;
   endfunction

   // Division rounded to nearest, ties away from zero.
   function automatic longint round_div(longint n, longint d);
      bit neg;
      longint unsigned un, ud, q;
      neg = (n < 0) != (d < 0);
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = (2 * un + ud) / (2 * ud);
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint half_down(longint s);
      if (s >= 0) return s / 2;
      return -((-s + 1) / 2);
   endfunction

   function automatic void box_span(longint lo, longint hi,
                                    output logic [OUT_WIDTH-1:0] center,
                                    output logic [OUT_WIDTH-1:0] size);
      if (lo > hi) begin
         center = '0;
         size = '0;
      end else begin
         center = OUT_WIDTH'(half_down(lo + hi));
         size = OUT_WIDTH'(hi - lo);
      end
   endfunction

   // Triangulates one pair, folds a valid point into the running box and clears the box after a last pair.
   function automatic scene_point_type triangulate(pixel_pair_type p);
      scene_point_type r;
      longint disp, b, nz, nx, ny, px, py, pz;
      disp = longint'(p.left_x) - longint'(p.right_x);
      b = base_q;
      nz = -(longint'(focal_q) * b * 256);
      nx = (2 * longint'(p.left_x) - longint'(width_px) * 16) * b * 16;
      ny = (longint'(height_px) * 16 - (longint'(p.left_y) + longint'(p.right_y))) * b * 16;
      r.bad_disparity = (disp == 0);
      if (disp == 0) begin
         px = sign_limit(nx);
         py = sign_limit(ny);
         pz = sign_limit(nz);
      end else begin
         pz = clamp_out(round_div(nz, 256 * disp));
         px = clamp_out(round_div(nx, 32 * disp));
         py = clamp_out(round_div(ny, 32 * disp));
         if (px < box_lo_x) box_lo_x = px;
         if (px > box_hi_x) box_hi_x = px;
         if (py < box_lo_y) box_lo_y = py;
         if (py > box_hi_y) box_hi_y = py;
         if (pz < box_lo_z) box_lo_z = pz;
         if (pz > box_hi_z) box_hi_z = pz;
      end
      r.point_x = OUT_WIDTH'(px);
      r.point_y = OUT_WIDTH'(py);
      r.point_z = OUT_WIDTH'(pz);
      box_span(box_lo_x, box_hi_x, r.center_x, r.extent_x);
      box_span(box_lo_y, box_hi_y, r.center_y, r.extent_y);
      box_span(box_lo_z, box_hi_z, r.center_z, r.extent_z);
      r.summary_valid = p.last_pair;
      if (p.last_pair) clear_box();
      return r;
   endfunction

   function automatic void compare_field(string name, logic [OUT_WIDTH-1:0] exp_v,
                                         logic [OUT_WIDTH-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   // Offers one pair, idling first at the current sender rate. Valid is only
   // lowered while idling, so back-to-back transactions keep it high.
   task automatic send_pair(pixel_pair_type p);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid <= 1'b1;
      req_if.left_x <= p.left_x;
      req_if.left_y <= p.left_y;
      req_if.right_x <= p.right_x;
      req_if.right_y <= p.right_y;
      req_if.last_pair <= p.last_pair;
      do @(posedge clock); while (!req_if.ready);
      expected_points = {expected_points, triangulate(p)};
   endtask

   task automatic send_fields(int xl, int yl, int xr, int yr, bit last);
      pixel_pair_type p;
      p.left_x = COORD_W'(xl);
      p.left_y = COORD_W'(yl);
      p.right_x = COORD_W'(xr);
      p.right_y = COORD_W'(yr);
      p.last_pair = last;
      send_pair(p);
   endtask

   // Waits until every predicted point has come back and the block is quiet.
   task automatic drain();
      @(posedge clock);
      req_if.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         CSR_FOCAL:  focal_q = value;
         CSR_BASE:   base_q = value;
         CSR_WIDTH:  width_px = value[11:0];
         CSR_HEIGHT: height_px = value[11:0];
         default: ;
      endcase
   endtask

   // Rewrites all four registers while idle; the enable drops afterwards.
   task automatic program_rig(logic [CSR_W-1:0] f, logic [CSR_W-1:0] b,
                              logic [CSR_W-1:0] w, logic [CSR_W-1:0] h);
      drain();
      write_reg(CSR_FOCAL, f);
      write_reg(CSR_BASE, b);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Field extremes and the corner cases at the reset rig settings.
   task automatic test_directed();
      send_fields(0, 0, 0, 0, 0);                  // bad pair into an empty box
      send_fields(4800, 3600, 4800, 3600, 0);      // bad pair with zero numerators
      send_fields(32767, 32767, 32767, 32767, 0);  // bad pair at the far corner
      send_fields(32767, 0, 0, 32767, 0);          // widest positive disparity
      send_fields(0, 32767, 32767, 0, 0);          // widest negative disparity
      send_fields(4801, 3600, 4800, 3600, 0);      // one-sixteenth disparity
      send_fields(4800, 3600, 4799, 3601, 0);
      send_fields(6000, 2000, 5000, 2010, 1);      // closes the set
      send_fields(1234, 1111, 1234, 1112, 1);      // bad pair marked last
      send_fields(9000, 4000, 8200, 4000, 0);
      send_fields(100, 20000, 60, 20004, 0);
      send_fields(16384, 8192, 16000, 8190, 1);
   endtask

   // Register extremes, including zero and values past the stated ranges.
   task automatic test_register_extremes();
      program_rig(16'd0, 16'd0, 16'd1, 16'd1);
      send_fields(5000, 3000, 4000, 3001, 0);
      send_fields(5000, 3000, 5000, 3000, 1);
      program_rig(16'hFFFF, 16'hFFFF, 16'd2048, 16'd2048);
      send_fields(1, 32767, 0, 32767, 0);
      send_fields(32767, 0, 32766, 1, 0);
      send_fields(0, 0, 32767, 32767, 0);
      send_fields(0, 0, 0, 0, 1);
      program_rig(16'd1, 16'hFFFF, 16'hFFFF, 16'hF000);
      send_fields(20000, 9000, 19000, 9002, 0);
      send_fields(300, 200, 100, 201, 1);
      program_rig(16'hFFFF, 16'd1, 16'd4095, 16'd4095);
      send_fields(32000, 32000, 31999, 32001, 1);
   endtask

   // Mostly plausible matches with random content, plus bad and raw pairs.
   task automatic test_random(int n, int s_idle, int r_idle, bit hold);
      pixel_pair_type p;
      int d, kind;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      if (hold) hold_mode <= 1'b1;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(99);
         p.left_x = COORD_W'($urandom);
         p.left_y = COORD_W'($urandom);
         p.right_x = COORD_W'($urandom);
         p.right_y = COORD_W'($urandom);
         if (kind < 70) begin
            d = $urandom_range(1, 2048);
            if ($urandom_range(9) == 0) d = -d;
            if (int'(p.left_x) - d < 0 || int'(p.left_x) - d > 32767) d = -d;
            p.right_x = COORD_W'(int'(p.left_x) - d);
            p.right_y = COORD_W'(int'(p.left_y) + int'($urandom_range(0, 32)) - 16);
         end else if (kind < 80) begin
            p.right_x = p.left_x;
         end
         p.last_pair = ($urandom_range(9) == 0);
         send_pair(p);
      end
   endtask

   // Response side: check each transaction, then pick the next ready value.
   always @(posedge clock) begin
      scene_point_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_points.size() == 0) begin
            $error("response with no pending prediction");
            mismatches++;
         end else begin
            e = expected_points.pop_front();
            compare_field("point_x", e.point_x, rsp_if.point_x);
            compare_field("point_y", e.point_y, rsp_if.point_y);
            compare_field("point_z", e.point_z, rsp_if.point_z);
            compare_field("bad_disparity", OUT_WIDTH'(e.bad_disparity),
                          OUT_WIDTH'(rsp_if.bad_disparity));
            compare_field("center_x", e.center_x, rsp_if.center_x);
            compare_field("center_y", e.center_y, rsp_if.center_y);
            compare_field("center_z", e.center_z, rsp_if.center_z);
            compare_field("extent_x", e.extent_x, rsp_if.extent_x);
            compare_field("extent_y", e.extent_y, rsp_if.extent_y);
            compare_field("extent_z", e.extent_z, rsp_if.extent_z);
            compare_field("summary_valid", OUT_WIDTH'(e.summary_valid),
                          OUT_WIDTH'(rsp_if.summary_valid));
         end
      end
      if (hold_mode && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles where neither channel completes a transaction.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.left_x = '0;
      req_if.left_y = '0;
      req_if.right_x = '0;
      req_if.right_y = '0;
      req_if.last_pair = 1'b0;
      rsp_if.ready = 1'b0;
      focal_q = 16'd11968;
      base_q = 16'd2560;
      width_px = 12'd600;
      height_px = 12'd450;
      clear_box();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_register_extremes();
      program_rig(16'd11968, 16'd2560, 16'd640, 16'd480);
      test_random(250, 17, 58, 1'b0);
      program_rig(CSR_W'($urandom), CSR_W'($urandom), CSR_W'($urandom), CSR_W'($urandom));
      test_random(250, 58, 17, 1'b0);
      program_rig(CSR_W'($urandom_range(1, 65535)), CSR_W'($urandom_range(1, 65535)),
                  CSR_W'($urandom_range(1, 2048)), CSR_W'($urandom_range(1, 2048)));
      test_random(250, 0, 0, 1'b1);
      drain();

      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

/* filelist.f */
sv/spt_pkg.sv
sv/spt_if.sv
sv/spt_ctrl.sv
sv/spt_dp.sv
sv/stereo_point_triangulator.sv
sv/spt_checker.sv
dv/stereo_point_triangulator_tb.sv
